// ===== rtl/vdp_pkg.sv =====
// Shared types, constants and helper functions of the VGA DAC palette block.
package vdp_pkg;

  // Default number of palette entries.
  localparam int PALETTE_ENTRIES_DEFAULT = 16;

  // Widest palette address that the block supports (256 entries).
  localparam int ADDR_MAX_W = 8;

  // I/O port addresses of the DAC.
  localparam logic [15:0] PORT_INDEX = 16'h03C8;
  localparam logic [15:0] PORT_DATA  = 16'h03C9;

  // Colour component positions within an entry; DONE means the entry is complete.
  localparam logic [1:0] COMP_RED   = 2'd0;
  localparam logic [1:0] COMP_GREEN = 2'd1;
  localparam logic [1:0] COMP_BLUE  = 2'd2;
  localparam logic [1:0] COMP_DONE  = 2'd3;

  // Result status codes.
  typedef enum logic [2:0] {
    ERR_OK           = 3'd0,
    ERR_BAD_INDEX    = 3'd1,
    ERR_UNARMED      = 3'd2,
    ERR_UNKNOWN_PORT = 3'd3,
    ERR_OVERFLOW     = 3'd4
  } err_code_t;

  // Command word: a port write or a pixel lookup.
  typedef struct packed {
    logic        cmd;
    logic [15:0] port;
    logic [7:0]  data;
    logic [7:0]  palette_index;
  } in_word_t;

  // Response word: looked-up colour and status.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [2:0] error_code;
  } out_word_t;

  // Decoded control for one accepted word, from the controller to the datapath.
  typedef struct packed {
    logic                  rd_en;
    logic [ADDR_MAX_W-1:0] rd_addr;
    logic [2:0]            wr_en;
    logic [ADDR_MAX_W-1:0] wr_addr;
    logic [7:0]            wr_data;
    err_code_t             err;
  } ctrl_t;

  // Colour an entry holds after reset: eight primaries, repeated once; zero above.
  function automatic logic [23:0] reset_colour(input logic [ADDR_MAX_W-1:0] idx);
    logic [23:0] colour;
    colour = '0;
    if (idx[ADDR_MAX_W-1:4] == '0) begin
      colour = {{8{idx[2]}}, {8{idx[1]}}, {8{idx[0]}}};
    end
    return colour;
  endfunction

endpackage

// ===== rtl/vdp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module vdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/vdp_ctrl.sv =====
// Command decoder and DAC write-pointer state of the palette block.
module vdp_ctrl #(
  parameter int PALETTE_ENTRIES = vdp_pkg::PALETTE_ENTRIES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  vdp_pkg::in_word_t word,
  output vdp_pkg::ctrl_t    ctrl
);
  import vdp_pkg::*;

  localparam int IDX_W = $clog2(PALETTE_ENTRIES);
  localparam logic [ADDR_MAX_W:0] ENTRIES = (ADDR_MAX_W + 1)'(PALETTE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(PALETTE_ENTRIES - 1);

  logic [IDX_W-1:0] write_index, write_index_next;
  logic [1:0]       component_count, component_count_next;
  logic             armed, armed_next;

  logic [IDX_W-1:0] slot;
  logic [1:0]       part;
  logic [2:0]       comp_sel;
  logic             do_write;
  ctrl_t            dec;

  // Decode the word against the current write pointer.
  always_comb begin
    dec                  = '0;
    dec.err              = ERR_OK;
    dec.wr_data          = word.data;
    write_index_next     = write_index;
    component_count_next = component_count;
    armed_next           = armed;
    slot                 = write_index;
    part                 = component_count;
    do_write             = 1'b0;

    if (word.cmd) begin
      // Pixel lookup.
      if ({1'b0, word.palette_index} >= ENTRIES) begin
        dec.err = ERR_BAD_INDEX;
      end else begin
        dec.rd_en   = 1'b1;
        dec.rd_addr = word.palette_index;
      end
    end else begin
      case (word.port)
        PORT_INDEX: begin
          if ({1'b0, word.data} >= ENTRIES) begin
            dec.err = ERR_BAD_INDEX;
          end else begin
            write_index_next     = word.data[IDX_W-1:0];
            component_count_next = COMP_RED;
            armed_next           = 1'b1;
          end
        end
        PORT_DATA: begin
          if (!armed) begin
            dec.err = ERR_UNARMED;
          end else if (component_count == COMP_DONE && write_index == LAST_ENTRY) begin
            dec.err = ERR_OVERFLOW;
          end else begin
            if (component_count == COMP_DONE) begin
              slot = write_index + 1'b1;
              part = COMP_RED;
            end
            do_write             = 1'b1;
            write_index_next     = slot;
            component_count_next = part + 2'd1;
          end
        end
        default: begin
          dec.err = ERR_UNKNOWN_PORT;
        end
      endcase
    end
  end

  // One-hot select of the component memory being written.
  always_comb begin
    case (part)
      COMP_RED:   comp_sel = 3'b001;
      COMP_GREEN: comp_sel = 3'b010;
      COMP_BLUE:  comp_sel = 3'b100;
      default:    comp_sel = 3'b000;
    endcase
  end

  // Gate memory strobes with the handshake.
  always_comb begin
    ctrl         = dec;
    ctrl.rd_en   = dec.rd_en && accept;
    ctrl.wr_en   = (do_write && accept) ? comp_sel : 3'b000;
    ctrl.wr_addr = ADDR_MAX_W'(slot);
  end

  // Write pointer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index     <= '0;
      component_count <= COMP_RED;
      armed           <= 1'b0;
    end else if (accept) begin
      write_index     <= write_index_next;
      component_count <= component_count_next;
      armed           <= armed_next;
    end
  end

  // The pointer only moves once an index write has armed the DAC.
  a_idle_pointer: assert property (@(posedge clk) disable iff (rst)
    !armed |-> (write_index == '0) && (component_count == COMP_RED))
    else $error("write pointer moved while the DAC was not armed");

  // A lookup never shares a cycle with a palette write.
  a_rw_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.rd_en && (ctrl.wr_en != 3'b000)))
    else $error("palette read and write issued together");

  // At most one colour component takes the data byte per word.
  a_one_component: assert property (@(posedge clk) disable iff (rst)
    $onehot0(ctrl.wr_en))
    else $error("more than one colour component written");

  // A rejected word leaves the pointer untouched.
  a_error_keeps_state: assert property (@(posedge clk) disable iff (rst)
    accept && (ctrl.err != ERR_OK) |=>
      $stable(write_index) && $stable(component_count) && $stable(armed))
    else $error("pointer state changed on an error");

  // A completed data write leaves at least one component stored.
  a_write_counts: assert property (@(posedge clk) disable iff (rst)
    (ctrl.wr_en != 3'b000) |=> armed && (component_count != COMP_RED))
    else $error("component count did not advance after a data write");

endmodule

// ===== rtl/vga_dac_palette.sv =====
// Top level of the VGA DAC palette: handshake, palette memories and response register.
// The response word is valid in the cycle after the command word is accepted.
// Throughput: one command word per cycle while the response is not stalled; each component
// memory has one write and one registered read port, used at most once per lookup or write.
// Reset: the write pointer is cleared, the DAC disarmed and one valid bit per entry cleared;
// an entry reads as its reset colour until first written. No clearing pass.
module vga_dac_palette #(
  parameter int PALETTE_ENTRIES = vdp_pkg::PALETTE_ENTRIES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  vdp_pkg::in_word_t  cmd_word,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output vdp_pkg::out_word_t rsp_word
);
  import vdp_pkg::*;

  localparam int IDX_W = $clog2(PALETTE_ENTRIES);

  logic        accept;
  ctrl_t       ctrl;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [7:0]  rd_data [3];

  logic [PALETTE_ENTRIES-1:0] entry_valid;
  logic        wr_any;
  logic        wr_fresh;
  logic [23:0] wr_default;
  logic [2:0]  ram_we;
  logic [7:0]  ram_wdata [3];

  logic        hit;
  logic        hit_valid;
  logic [23:0] hit_default;
  err_code_t   err;

  // A new word is taken whenever the response register is free or draining.
  assign cmd_ready = !rsp_valid || rsp_ready;
  assign accept    = cmd_valid && cmd_ready;

  assign rd_addr = ctrl.rd_addr[IDX_W-1:0];
  assign wr_addr = ctrl.wr_addr[IDX_W-1:0];

  vdp_ctrl #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .word   (cmd_word),
    .ctrl   (ctrl)
  );

  // The first write to an entry also stores the reset colour of its other components,
  // so a single valid bit per entry tells stored from reset colour.
  assign wr_any     = |ctrl.wr_en;
  assign wr_fresh   = !entry_valid[wr_addr];
  assign wr_default = reset_colour(ctrl.wr_addr);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ram_we[c]    = ctrl.wr_en[c] || (wr_any && wr_fresh);
      ram_wdata[c] = ctrl.wr_en[c] ? ctrl.wr_data : wr_default[23-8*c -: 8];
    end
  end

  // One memory per colour component, so each data write stores a single byte.
  for (genvar c = 0; c < 3; c++) begin : g_comp
    vdp_ram #(
      .WIDTH (8),
      .DEPTH (PALETTE_ENTRIES)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we[c]),
      .waddr (wr_addr),
      .wdata (ram_wdata[c]),
      .re    (ctrl.rd_en),
      .raddr (rd_addr),
      .rdata (rd_data[c])
    );
  end

  // Valid bits mark entries written since reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_any) begin
      entry_valid[wr_addr] <= 1'b1;
    end
  end

  // Response register: status, hit flag and the fallback colour of the looked-up entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd_ready) begin
      rsp_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err <= ctrl.err;
      hit <= ctrl.rd_en;
      if (ctrl.rd_en) begin
        hit_valid   <= entry_valid[rd_addr];
        hit_default <= reset_colour(ctrl.rd_addr);
      end
    end
  end

  // Pick stored or reset colour; zero unless the lookup succeeded.
  always_comb begin
    rsp_word            = '0;
    rsp_word.error_code = err;
    if (hit) begin
      rsp_word.red   = hit_valid ? rd_data[0] : hit_default[23:16];
      rsp_word.green = hit_valid ? rd_data[1] : hit_default[15:8];
      rsp_word.blue  = hit_valid ? rd_data[2] : hit_default[7:0];
    end
  end

  // A successful lookup always reports status OK.
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && hit |-> rsp_word.error_code == ERR_OK)
    else $error("lookup hit reported with an error status");

  // Failed words carry no colour.
  a_miss_black: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_word.error_code != ERR_OK) |->
      (rsp_word.red == 8'd0) && (rsp_word.green == 8'd0) && (rsp_word.blue == 8'd0))
    else $error("colour returned with an error status");

  // A stalled response keeps its status.
  a_hold_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(err) && $stable(hit))
    else $error("response changed while stalled");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the VGA DAC palette: stimulus queue, driver, monitor, predictor.
module testbench;
  import vdp_pkg::*;

  localparam int ENTRIES = PALETTE_ENTRIES_DEFAULT;
  localparam int RANDOM_WORDS = 1200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  logic clk;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  in_word_t cmd_word = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  out_word_t rsp_word;

  // Words waiting to be sent and responses still owed by the block.
  in_word_t cmd_backlog[$];
  out_word_t owed_responses[$];

  // Shadow copy of the palette and the DAC write pointer.
  logic [23:0] palette_shadow [ENTRIES];
  int unsigned shadow_slot;
  logic [1:0] shadow_comp;
  bit shadow_armed;

  int send_wait;
  int recv_wait;
  bit send_calm;
  bit recv_calm;
  int cycle_count;
  int mismatches;
  int checked;
  int port_writes;
  int lookups;
  int status_seen [5];

  vga_dac_palette #(
    .PALETTE_ENTRIES(ENTRIES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_word(cmd_word),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_word(rsp_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Idle span before the next word; now and then switch between quiet and busy stretches.
  function automatic int idle_span(inout bit calm);
    if ($urandom_range(0, 59) == 0) begin
      calm = !calm;
    end
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  // Port write word; the lookup index is ignored by the block and left random.
  function automatic in_word_t port_word(logic [15:0] addr, logic [7:0] value);
    in_word_t w;
    w.cmd = 1'b0;
    w.port = addr;
    w.data = value;
    w.palette_index = 8'($urandom_range(0, 255));
    return w;
  endfunction

  // Lookup word; port and data are ignored by the block and left random.
  function automatic in_word_t lookup_word(logic [7:0] idx);
    in_word_t w;
    w.cmd = 1'b1;
    w.port = 16'($urandom_range(0, 65535));
    w.data = 8'($urandom_range(0, 255));
    w.palette_index = idx;
    return w;
  endfunction

  // Expected response to one accepted word; updates the shadow palette and pointer.
  function automatic out_word_t dac_response(in_word_t w);
    out_word_t r;
    int unsigned slot;
    logic [1:0] part;
    r = '0;
    r.error_code = ERR_OK;
    if (w.cmd) begin
      if (w.palette_index >= ENTRIES) begin
        r.error_code = ERR_BAD_INDEX;
      end else begin
        {r.red, r.green, r.blue} = palette_shadow[w.palette_index];
      end
    end else if (w.port == PORT_INDEX) begin
      if (w.data >= ENTRIES) begin
        r.error_code = ERR_BAD_INDEX;
      end else begin
        shadow_slot = {24'd0, w.data};
        shadow_comp = COMP_RED;
        shadow_armed = 1'b1;
      end
    end else if (w.port == PORT_DATA) begin
      if (!shadow_armed) begin
        r.error_code = ERR_UNARMED;
      end else begin
        slot = shadow_slot;
        part = shadow_comp;
        // A finished entry steps to the next one, unless it was the last.
        if (part == COMP_DONE && slot + 1 >= ENTRIES) begin
          r.error_code = ERR_OVERFLOW;
        end else begin
          if (part == COMP_DONE) begin
            slot++;
            part = COMP_RED;
          end
          case (part)
            COMP_RED: palette_shadow[slot][23:16] = w.data;
            COMP_GREEN: palette_shadow[slot][15:8] = w.data;
            default: palette_shadow[slot][7:0] = w.data;
          endcase
          shadow_slot = slot;
          shadow_comp = part + 2'd1;
        end
      end
    end else begin
      r.error_code = ERR_UNKNOWN_PORT;
    end
    return r;
  endfunction

  // Driver: present the next word once the previous one is taken and its gap has passed.
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      send_wait = 0;
    end else if (!cmd_valid || cmd_ready) begin
      if (send_wait > 0) begin
        send_wait--;
        cmd_valid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        cmd_word <= cmd_backlog.pop_front();
        cmd_valid <= 1'b1;
        send_wait = idle_span(send_calm);
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // Monitor: check the response word first, then record the word the block just took.
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst) begin
      rsp_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        checked++;
        if (owed_responses.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("Unexpected response word: red %h green %h blue %h status %0d",
                     rsp_word.red, rsp_word.green, rsp_word.blue, rsp_word.error_code);
          end
        end else begin
          exp_w = owed_responses.pop_front();
          if (rsp_word.red !== exp_w.red || rsp_word.green !== exp_w.green ||
              rsp_word.blue !== exp_w.blue || rsp_word.error_code !== exp_w.error_code) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("Mismatch at response %0d: expected %h/%h/%h status %0d,",
                       checked, exp_w.red, exp_w.green, exp_w.blue, exp_w.error_code,
                       " got %h/%h/%h status %0d",
                       rsp_word.red, rsp_word.green, rsp_word.blue, rsp_word.error_code);
            end
          end
        end
        recv_wait = idle_span(recv_calm);
        rsp_ready <= (recv_wait == 0);
      end else if (recv_wait > 0) begin
        recv_wait--;
        rsp_ready <= (recv_wait == 0);
      end else begin
        rsp_ready <= 1'b1;
      end
      if (cmd_valid && cmd_ready) begin
        exp_w = dac_response(cmd_word);
        owed_responses.push_back(exp_w);
        status_seen[exp_w.error_code]++;
        if (cmd_word.cmd) begin
          lookups++;
        end else begin
          port_writes++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d responses outstanding",
               cycle_count, owed_responses.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int made;
    int burst;
    int kind;
    logic [7:0] entry;
    logic [15:0] noise_port;

    // Shadow palette after reset: eight primaries, then the same eight again.
    for (int n = 0; n < ENTRIES; n++) begin
      entry = 8'(n);
      palette_shadow[n] = (n < 16) ? {{8{entry[2]}}, {8{entry[1]}}, {8{entry[0]}}} : 24'h0;
    end
    shadow_slot = 0;
    shadow_comp = COMP_RED;
    shadow_armed = 1'b0;

    // Directed words: data before arming, reset colours, range errors, unknown ports,
    // a fill that runs into the end of the palette, and a partly written entry.
    cmd_backlog.push_back(port_word(PORT_DATA, 8'hAB));
    cmd_backlog.push_back(lookup_word(8'd0));
    cmd_backlog.push_back(lookup_word(8'd7));
    cmd_backlog.push_back(lookup_word(8'd10));
    cmd_backlog.push_back(lookup_word(8'(ENTRIES - 1)));
    cmd_backlog.push_back(lookup_word(8'(ENTRIES)));
    cmd_backlog.push_back(lookup_word(8'hFF));
    cmd_backlog.push_back(port_word(16'h0000, 8'h00));
    cmd_backlog.push_back(port_word(16'hFFFF, 8'hFF));
    cmd_backlog.push_back(port_word(PORT_DATA + 16'd1, 8'h12));
    cmd_backlog.push_back(port_word(PORT_INDEX, 8'(ENTRIES)));
    cmd_backlog.push_back(port_word(PORT_INDEX, 8'hFF));
    cmd_backlog.push_back(port_word(PORT_INDEX, 8'(ENTRIES - 2)));
    cmd_backlog.push_back(port_word(PORT_DATA, 8'h00));
    cmd_backlog.push_back(port_word(PORT_DATA, 8'hFF));
    cmd_backlog.push_back(port_word(PORT_DATA, 8'h5A));
    cmd_backlog.push_back(port_word(PORT_DATA, 8'hA5));
    cmd_backlog.push_back(port_word(PORT_DATA, 8'h3C));
    cmd_backlog.push_back(port_word(PORT_DATA, 8'hC3));
    cmd_backlog.push_back(port_word(PORT_DATA, 8'h77));
    cmd_backlog.push_back(lookup_word(8'(ENTRIES - 2)));
    cmd_backlog.push_back(lookup_word(8'(ENTRIES - 1)));
    cmd_backlog.push_back(port_word(PORT_INDEX, 8'd0));
    cmd_backlog.push_back(port_word(PORT_DATA, 8'hFF));
    cmd_backlog.push_back(lookup_word(8'd0));

    // Random part: mostly index-then-data fills with lookups mixed in, plus noise.
    made = 0;
    while (made < RANDOM_WORDS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        entry = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(ENTRIES - 4, ENTRIES - 1))
                                            : 8'($urandom_range(0, ENTRIES - 1));
        cmd_backlog.push_back(port_word(PORT_INDEX, entry));
        made++;
        burst = $urandom_range(1, 15);
        for (int k = 0; k < burst; k++) begin
          if ($urandom_range(0, 3) == 0) begin
            cmd_backlog.push_back(lookup_word(8'($urandom_range(0, ENTRIES - 1))));
          end else begin
            cmd_backlog.push_back(port_word(PORT_DATA, 8'($urandom_range(0, 255))));
          end
          made++;
        end
      end else if (kind <= 7) begin
        burst = $urandom_range(1, 6);
        for (int k = 0; k < burst; k++) begin
          cmd_backlog.push_back(lookup_word(8'($urandom_range(0, ENTRIES - 1))));
          made++;
        end
      end else if (kind == 8) begin
        case ($urandom_range(0, 2))
          0: noise_port = 16'($urandom_range(0, 65535));
          1: noise_port = PORT_INDEX ^ (16'h1 << $urandom_range(0, 15));
          default: noise_port = PORT_INDEX;
        endcase
        if (noise_port == PORT_INDEX) begin
          cmd_backlog.push_back(port_word(noise_port, 8'($urandom_range(ENTRIES, 255))));
        end else begin
          cmd_backlog.push_back(port_word(noise_port, 8'($urandom_range(0, 255))));
        end
        made++;
      end else begin
        cmd_backlog.push_back(lookup_word(8'($urandom_range(ENTRIES, 255))));
        made++;
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for every word to be taken and every response to come back.
    while (cmd_backlog.size() != 0 || cmd_valid) begin
      @(posedge clk);
    end
    while (owed_responses.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    if (owed_responses.size() != 0) begin
      mismatches++;
    end
    $display("Checked %0d responses to %0d port writes and %0d lookups.",
             checked, port_writes, lookups);
    $display("Status mix ok/bad index/unarmed/unknown port/overflow: %0d/%0d/%0d/%0d/%0d",
             status_seen[ERR_OK], status_seen[ERR_BAD_INDEX], status_seen[ERR_UNARMED],
             status_seen[ERR_UNKNOWN_PORT], status_seen[ERR_OVERFLOW]);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== vga_dac_palette.f =====
rtl/vdp_pkg.sv
rtl/vdp_ram.sv
rtl/vdp_ctrl.sv
rtl/vga_dac_palette.sv
verif/testbench.sv
